>>> rtl/core/rvid_pkg.sv
// ----------------------------------------------------------------------------
// rvid_pkg
// Shared codes, opcodes and the decoded-result record of the RV32I decoder.
// ----------------------------------------------------------------------------
package rvid_pkg;

    localparam int unsigned XLEN = 32;

    // major opcodes
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // funct3 values
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3 codes of the branch format
    localparam logic [2:0] F3_BEQ     = 3'd0;
    localparam logic [2:0] F3_BNE     = 3'd1;
    localparam logic [2:0] F3_BR_RSV2 = 3'd2;
    localparam logic [2:0] F3_BR_RSV3 = 3'd3;
    localparam logic [2:0] F3_BLT     = 3'd4;
    localparam logic [2:0] F3_BGE     = 3'd5;
    localparam logic [2:0] F3_BLTU    = 3'd6;
    localparam logic [2:0] F3_BGEU    = 3'd7;

    // funct3 codes of the load and store formats
    localparam logic [2:0] F3_BYTE   = 3'd0;
    localparam logic [2:0] F3_HALF   = 3'd1;
    localparam logic [2:0] F3_BYTE_U = 3'd4;
    localparam logic [2:0] F3_HALF_U = 3'd5;

    // instruction class
    localparam logic [2:0] CL_ALU     = 3'd0;
    localparam logic [2:0] CL_LOAD    = 3'd1;
    localparam logic [2:0] CL_STORE   = 3'd2;
    localparam logic [2:0] CL_BRANCH  = 3'd3;
    localparam logic [2:0] CL_JUMP    = 3'd4;
    localparam logic [2:0] CL_INVALID = 3'd5;

    // alu operations
    localparam logic [3:0] ALU_ADD  = 4'd0;
    localparam logic [3:0] ALU_SUB  = 4'd1;
    localparam logic [3:0] ALU_SLL  = 4'd2;
    localparam logic [3:0] ALU_SLT  = 4'd3;
    localparam logic [3:0] ALU_SLTU = 4'd4;
    localparam logic [3:0] ALU_XOR  = 4'd5;
    localparam logic [3:0] ALU_SRL  = 4'd6;
    localparam logic [3:0] ALU_SRA  = 4'd7;
    localparam logic [3:0] ALU_OR   = 4'd8;
    localparam logic [3:0] ALU_AND  = 4'd9;

    // memory operations
    localparam logic [2:0] MEM_LB  = 3'd0;
    localparam logic [2:0] MEM_LH  = 3'd1;
    localparam logic [2:0] MEM_LW  = 3'd2;
    localparam logic [2:0] MEM_LBU = 3'd3;
    localparam logic [2:0] MEM_LHU = 3'd4;
    localparam logic [2:0] MEM_SB  = 3'd5;
    localparam logic [2:0] MEM_SH  = 3'd6;
    localparam logic [2:0] MEM_SW  = 3'd7;

    // branch operations
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd2;
    localparam logic [2:0] BR_GE  = 3'd3;
    localparam logic [2:0] BR_LTU = 3'd4;
    localparam logic [2:0] BR_GEU = 3'd5;

    localparam logic [XLEN-1:0] LINK_OFFSET = 32'd4;

    typedef struct packed {
        logic [2:0]      op_class;
        logic [3:0]      alu_op;
        logic [2:0]      mem_op;
        logic [2:0]      br_op;
        logic [XLEN-1:0] operand_one;
        logic [XLEN-1:0] operand_two;
        logic [XLEN-1:0] store_value;
        logic [4:0]      dest_reg;
        logic            write_enable;
        logic [XLEN-1:0] next_pc;
    } t_dec_res;

endpackage

>>> rtl/core/rvid_if.sv
// ----------------------------------------------------------------------------
// rvid_in_if / rvid_out_if
// Valid/ready channels carrying fetched instruction words and decoded words.
// ----------------------------------------------------------------------------
interface rvid_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    logic [31:0] fetch_pc;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;

    modport source (
        output valid, instruction_word, fetch_pc, rs1_value, rs2_value,
        input  ready
    );
    modport sink (
        input  valid, instruction_word, fetch_pc, rs1_value, rs2_value,
        output ready
    );
endinterface

interface rvid_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op_class;
    logic [3:0]  alu_op;
    logic [2:0]  mem_op;
    logic [2:0]  br_op;
    logic [31:0] operand_one;
    logic [31:0] operand_two;
    logic [31:0] store_value;
    logic [4:0]  dest_reg;
    logic        write_enable;
    logic [31:0] next_pc;

    modport source (
        output valid, op_class, alu_op, mem_op, br_op, operand_one, operand_two,
               store_value, dest_reg, write_enable, next_pc,
        input  ready
    );
    modport sink (
        input  valid, op_class, alu_op, mem_op, br_op, operand_one, operand_two,
               store_value, dest_reg, write_enable, next_pc,
        output ready
    );
endinterface

>>> rtl/core/rvid_decode.sv
// ----------------------------------------------------------------------------
// rvid_decode
// Combinational RV32I field decode, immediate build and next-pc adder.
// ----------------------------------------------------------------------------
module rvid_decode (
    input  logic [31:0]        i_word,
    input  logic [31:0]        i_pc,
    input  logic [31:0]        i_rs1,
    input  logic [31:0]        i_rs2,
    output rvid_pkg::t_dec_res o_res
);

    logic [6:0]  w_opc;
    logic [2:0]  w_f3;
    logic [6:0]  w_f7;
    logic [4:0]  w_rd;
    logic [31:0] w_imm_i;
    logic [31:0] w_imm_s;
    logic [31:0] w_imm_b;
    logic [31:0] w_imm_u;
    logic [31:0] w_imm_j;
    logic [31:0] w_tgt_base;
    logic [31:0] w_tgt_off;
    logic [31:0] w_tgt_sum;
    logic [31:0] w_pc_inc;

    assign w_opc = i_word[6:0];
    assign w_f3  = i_word[14:12];
    assign w_f7  = i_word[31:25];
    assign w_rd  = i_word[11:7];

    assign w_imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign w_imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign w_imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                      i_word[11:8], 1'b0};
    assign w_imm_u = {i_word[31:12], 12'd0};
    assign w_imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                      i_word[30:21], 1'b0};

    // one shared target adder for jal, jalr and branches
    assign w_tgt_base = (w_opc == rvid_pkg::OPC_JALR) ? i_rs1 : i_pc;
    assign w_tgt_off  = (w_opc == rvid_pkg::OPC_JALR) ? w_imm_i :
                        (w_opc == rvid_pkg::OPC_JAL)  ? w_imm_j : w_imm_b;
    assign w_tgt_sum  = w_tgt_base + w_tgt_off;
    assign w_pc_inc   = i_pc + rvid_pkg::LINK_OFFSET;

    always_comb begin
        o_res              = '0;
        o_res.op_class     = rvid_pkg::CL_INVALID;
        o_res.alu_op       = rvid_pkg::ALU_ADD;
        o_res.next_pc      = w_pc_inc;
        unique case (w_opc)
            rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC: begin
                o_res.op_class     = rvid_pkg::CL_ALU;
                o_res.operand_one  = (w_opc == rvid_pkg::OPC_LUI) ? 32'd0 : i_pc;
                o_res.operand_two  = w_imm_u;
                o_res.dest_reg     = w_rd;
                o_res.write_enable = 1'b1;
            end
            rvid_pkg::OPC_JAL, rvid_pkg::OPC_JALR: begin
                o_res.op_class     = rvid_pkg::CL_JUMP;
                o_res.operand_one  = i_pc;
                o_res.operand_two  = rvid_pkg::LINK_OFFSET;
                o_res.dest_reg     = w_rd;
                o_res.write_enable = 1'b1;
                o_res.next_pc      = (w_opc == rvid_pkg::OPC_JALR) ?
                                     {w_tgt_sum[31:1], 1'b0} : w_tgt_sum;
            end
            rvid_pkg::OPC_BRANCH: begin
                if (w_f3 != rvid_pkg::F3_BR_RSV2 && w_f3 != rvid_pkg::F3_BR_RSV3) begin
                    o_res.op_class    = rvid_pkg::CL_BRANCH;
                    o_res.operand_one = i_rs1;
                    o_res.operand_two = i_rs2;
                    o_res.next_pc     = w_tgt_sum;
                    unique case (w_f3)
                        rvid_pkg::F3_BEQ:  o_res.br_op = rvid_pkg::BR_EQ;
                        rvid_pkg::F3_BNE:  o_res.br_op = rvid_pkg::BR_NE;
                        rvid_pkg::F3_BLT:  o_res.br_op = rvid_pkg::BR_LT;
                        rvid_pkg::F3_BGE:  o_res.br_op = rvid_pkg::BR_GE;
                        rvid_pkg::F3_BLTU: o_res.br_op = rvid_pkg::BR_LTU;
                        rvid_pkg::F3_BGEU: o_res.br_op = rvid_pkg::BR_GEU;
                        default:           o_res.br_op = rvid_pkg::BR_EQ;
                    endcase
                end
            end
            rvid_pkg::OPC_LOAD: begin
                o_res.op_class     = rvid_pkg::CL_LOAD;
                o_res.operand_one  = i_rs1;
                o_res.operand_two  = w_imm_i;
                o_res.dest_reg     = w_rd;
                o_res.write_enable = 1'b1;
                // unknown widths fall back to a full word
                unique case (w_f3)
                    rvid_pkg::F3_BYTE:   o_res.mem_op = rvid_pkg::MEM_LB;
                    rvid_pkg::F3_HALF:   o_res.mem_op = rvid_pkg::MEM_LH;
                    rvid_pkg::F3_BYTE_U: o_res.mem_op = rvid_pkg::MEM_LBU;
                    rvid_pkg::F3_HALF_U: o_res.mem_op = rvid_pkg::MEM_LHU;
                    default:             o_res.mem_op = rvid_pkg::MEM_LW;
                endcase
            end
            rvid_pkg::OPC_STORE: begin
                o_res.op_class    = rvid_pkg::CL_STORE;
                o_res.operand_one = i_rs1;
                o_res.operand_two = w_imm_s;
                o_res.store_value = i_rs2;
                unique case (w_f3)
                    rvid_pkg::F3_BYTE: o_res.mem_op = rvid_pkg::MEM_SB;
                    rvid_pkg::F3_HALF: o_res.mem_op = rvid_pkg::MEM_SH;
                    default:           o_res.mem_op = rvid_pkg::MEM_SW;
                endcase
            end
            rvid_pkg::OPC_OPIMM: begin
                o_res.op_class     = rvid_pkg::CL_ALU;
                o_res.operand_one  = i_rs1;
                o_res.operand_two  = w_imm_i;
                o_res.dest_reg     = w_rd;
                o_res.write_enable = 1'b1;
                unique case (w_f3)
                    rvid_pkg::F3_ADD:  o_res.alu_op = rvid_pkg::ALU_ADD;
                    rvid_pkg::F3_SLL:  o_res.alu_op = rvid_pkg::ALU_SLL;
                    rvid_pkg::F3_SLT:  o_res.alu_op = rvid_pkg::ALU_SLT;
                    rvid_pkg::F3_SLTU: o_res.alu_op = rvid_pkg::ALU_SLTU;
                    rvid_pkg::F3_XOR:  o_res.alu_op = rvid_pkg::ALU_XOR;
                    rvid_pkg::F3_SR:   o_res.alu_op = (w_f7 == rvid_pkg::F7_ALT) ?
                                                      rvid_pkg::ALU_SRA :
                                                      rvid_pkg::ALU_SRL;
                    rvid_pkg::F3_OR:   o_res.alu_op = rvid_pkg::ALU_OR;
                    default:           o_res.alu_op = rvid_pkg::ALU_AND;
                endcase
                // shift immediates only allow the legal upper patterns: base for left, base or alt for right
                if ((w_f3 == rvid_pkg::F3_SLL && w_f7 != rvid_pkg::F7_BASE) ||
                    (w_f3 == rvid_pkg::F3_SR && w_f7 != rvid_pkg::F7_BASE &&
                     w_f7 != rvid_pkg::F7_ALT)) begin
                    o_res = '0;
                    o_res.op_class = rvid_pkg::CL_INVALID;
                    o_res.next_pc  = w_pc_inc;
                end
            end
            rvid_pkg::OPC_OP: begin
                if (w_f7 == rvid_pkg::F7_BASE ||
                    (w_f7 == rvid_pkg::F7_ALT &&
                     (w_f3 == rvid_pkg::F3_ADD || w_f3 == rvid_pkg::F3_SR))) begin
                    o_res.op_class     = rvid_pkg::CL_ALU;
                    o_res.operand_one  = i_rs1;
                    o_res.operand_two  = i_rs2;
                    o_res.dest_reg     = w_rd;
                    o_res.write_enable = 1'b1;
                    unique case (w_f3)
                        rvid_pkg::F3_ADD:  o_res.alu_op = (w_f7 == rvid_pkg::F7_ALT) ?
                                                          rvid_pkg::ALU_SUB :
                                                          rvid_pkg::ALU_ADD;
                        rvid_pkg::F3_SLL:  o_res.alu_op = rvid_pkg::ALU_SLL;
                        rvid_pkg::F3_SLT:  o_res.alu_op = rvid_pkg::ALU_SLT;
                        rvid_pkg::F3_SLTU: o_res.alu_op = rvid_pkg::ALU_SLTU;
                        rvid_pkg::F3_XOR:  o_res.alu_op = rvid_pkg::ALU_XOR;
                        rvid_pkg::F3_SR:   o_res.alu_op = (w_f7 == rvid_pkg::F7_ALT) ?
                                                          rvid_pkg::ALU_SRA :
                                                          rvid_pkg::ALU_SRL;
                        rvid_pkg::F3_OR:   o_res.alu_op = rvid_pkg::ALU_OR;
                        default:           o_res.alu_op = rvid_pkg::ALU_AND;
                    endcase
                end
            end
            default: begin
                o_res.op_class = rvid_pkg::CL_INVALID;
            end
        endcase
    end

endmodule

>>> rtl/core/rv32i_instruction_decode_unit.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_decode_unit
// RV32I decode stage: one instruction word in, one decoded word out, per cycle.
// Words are taken into an input register, decoded by short logic and held in a
// result register, so a new word is accepted every cycle unless the output stalls;
// its decoded word is offered on the output once the result register loads it.
// Throughput is one word per cycle while the sink takes results; a stalled
// result register holds the input register, and ready then drops only when
// both registers are full. Branch next_pc is the taken target; the condition
// itself is resolved downstream.
// ----------------------------------------------------------------------------
module rv32i_instruction_decode_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvid_in_if.sink     i_in,
    rvid_out_if.source  o_out
);

    logic               r_s1_valid;
    logic [31:0]        r_s1_word;
    logic [31:0]        r_s1_pc;
    logic [31:0]        r_s1_rs1;
    logic [31:0]        r_s1_rs2;
    logic               r_out_valid;
    rvid_pkg::t_dec_res r_out;
    rvid_pkg::t_dec_res n_out;
    logic               w_out_free;
    logic               w_s1_free;

    // result register can load when empty or being drained
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign i_in.ready = w_s1_free;

    rvid_decode u_decode (
        .i_word (r_s1_word),
        .i_pc   (r_s1_pc),
        .i_rs1  (r_s1_rs1),
        .i_rs2  (r_s1_rs2),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_in.valid) begin
            r_s1_word <= i_in.instruction_word;
            r_s1_pc   <= i_in.fetch_pc;
            r_s1_rs1  <= i_in.rs1_value;
            r_s1_rs2  <= i_in.rs2_value;
        end
        if (w_out_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.op_class     = r_out.op_class;
    assign o_out.alu_op       = r_out.alu_op;
    assign o_out.mem_op       = r_out.mem_op;
    assign o_out.br_op        = r_out.br_op;
    assign o_out.operand_one  = r_out.operand_one;
    assign o_out.operand_two  = r_out.operand_two;
    assign o_out.store_value  = r_out.store_value;
    assign o_out.dest_reg     = r_out.dest_reg;
    assign o_out.write_enable = r_out.write_enable;
    assign o_out.next_pc      = r_out.next_pc;

`ifndef ASSERT_OFF
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_out_free) |=> r_out_valid)
        else $error("decoded word lost between stages");

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |=> (r_s1_valid && $stable(r_s1_word)))
        else $error("input register changed during stall");

    a_no_wb_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.op_class == rvid_pkg::CL_INVALID ||
                         r_out.op_class == rvid_pkg::CL_STORE ||
                         r_out.op_class == rvid_pkg::CL_BRANCH))
        |-> (!r_out.write_enable && r_out.dest_reg == 5'd0))
        else $error("write-back flagged for a class without destination");

    a_jump_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.op_class == rvid_pkg::CL_JUMP)
        |-> (r_out.operand_two == rvid_pkg::LINK_OFFSET && r_out.write_enable))
        else $error("jump without link operands");
`endif

endmodule
